/* hdl/cps_pkg.sv */
package cps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 24;
    localparam int PART_W     = 2 * COORD_W;
    localparam int SQ_W       = 2 * COORD_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int OUT_IDX_W  = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      last_point;
    } cps_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0]    min_distance;
        logic [OUT_IDX_W-1:0] first_index;
        logic [OUT_IDX_W-1:0] second_index;
        logic                 pair_found;
        logic                 overflowed;
    } cps_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
    } pair_tag_t;

    typedef struct packed {
        pair_tag_t       tag;
        logic [SQ_W-1:0] square;
    } dist_res_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

endpackage

/* hdl/closest_pair_search_unit.sv */
// Channel   Direction  Payload    Transfer when
// s_        in         cps_in_t   s_valid && s_ready  (one point per transfer)
// m_        out        cps_out_t  m_valid && m_ready  (one result per closed set)
//
// Sequence: the transfer flagged last_point starts the search, or with fewer
// than two points goes straight to the result. The search issues one pair
// per cycle through the shared distance pipeline (memory read plus three
// stages); then come the drain, the square root (one root bit per cycle,
// then a one-cycle done pulse) and the load of the result register. The
// pair loop at one pair per cycle sets the rate.
// Reset: aresetn, synchronous, active low; clears the control state, the
// point count, the overflow flag and the best pair. The point memory is not
// cleared: only entries below the point count are ever read.
// Stalls: s_ready is high only while points are being loaded. A result held
// by a low m_ready does not stop loading of the next set; the next result
// waits until the held one has been taken.
module closest_pair_search_unit
    import cps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cps_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cps_out_t m_data
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [SQ_W-1:0]  best_sq_reg, best_sq_next;
    logic [IDX_W-1:0] best_first_reg, best_first_next;
    logic [IDX_W-1:0] best_second_reg, best_second_next;
    logic             m_valid_reg, m_valid_next;
    cps_out_t         m_data_reg, m_data_next;

    logic             in_xfer;
    logic             store_wr;
    logic [CNT_W-1:0] count_after;
    point_t           wr_point;
    point_t           rd_a, rd_b;
    pair_tag_t        issue_tag;
    pair_tag_t        rd_tag_reg;
    dist_res_t        dist_res;
    logic             dist_busy;
    logic             sqrt_start;
    sqrt_res_t        sqrt_res;

    assign s_ready  = (state_reg == ST_LOAD);
    assign in_xfer  = s_valid && s_ready;
    assign store_wr = in_xfer && (count_reg < CNT_W'(MAX_POINTS));
    assign count_after = store_wr ? count_reg + 1'b1 : count_reg;

    assign wr_point.x = s_data.x_coord;
    assign wr_point.y = s_data.y_coord;
    assign wr_point.z = s_data.z_coord;

    // issue one pair per cycle while searching
    assign issue_tag.valid  = (state_reg == ST_SEARCH);
    assign issue_tag.first  = i_reg[IDX_W-1:0];
    assign issue_tag.second = j_reg[IDX_W-1:0];

    cps_point_store u_store (
        .aclk      (aclk),
        .wr_en     (store_wr),
        .wr_addr   (count_reg[IDX_W-1:0]),
        .wr_data   (wr_point),
        .rd_addr_a (i_reg[IDX_W-1:0]),
        .rd_addr_b (j_reg[IDX_W-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // align the pair tag with the registered memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg.valid <= 1'b0;
        end else begin
            rd_tag_reg.valid <= issue_tag.valid;
        end
        rd_tag_reg.first  <= issue_tag.first;
        rd_tag_reg.second <= issue_tag.second;
    end

    cps_dist_unit u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (rd_tag_reg),
        .pt_a    (rd_a),
        .pt_b    (rd_b),
        .res     (dist_res),
        .busy    (dist_busy)
    );

    assign sqrt_start = (state_reg == ST_DRAIN) && !dist_busy && !rd_tag_reg.valid;

    cps_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (best_sq_reg),
        .res      (sqrt_res)
    );

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        drop_next        = drop_reg;
        found_next       = found_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        best_sq_next     = best_sq_reg;
        best_first_next  = best_first_reg;
        best_second_next = best_second_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;

        // keep the strictly smaller distance; pairs arrive in search order
        if (dist_res.tag.valid && (dist_res.square < best_sq_reg)) begin
            best_sq_next     = dist_res.square;
            best_first_next  = dist_res.tag.first;
            best_second_next = dist_res.tag.second;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    count_next = count_after;
                    if (!store_wr) begin
                        drop_next = 1'b1;
                    end
                    if (s_data.last_point) begin
                        i_next = '0;
                        j_next = CNT_W'(1);
                        if (count_after >= CNT_W'(2)) begin
                            found_next = 1'b1;
                            state_next = ST_SEARCH;
                        end else begin
                            found_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (j_reg == count_reg - 1'b1) begin
                    if (i_reg == count_reg - CNT_W'(2)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + CNT_W'(2);
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (sqrt_start) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_res.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the previous result has been taken
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.min_distance = found_reg ? sqrt_res.root : '0;
                    m_data_next.first_index  =
                        found_reg ? OUT_IDX_W'(best_first_reg) : '0;
                    m_data_next.second_index =
                        found_reg ? OUT_IDX_W'(best_second_reg) : '0;
                    m_data_next.pair_found   = found_reg;
                    m_data_next.overflowed   = drop_reg;
                    count_next       = '0;
                    drop_next        = 1'b0;
                    found_next       = 1'b0;
                    best_sq_next     = '1;
                    best_first_next  = '0;
                    best_second_next = '0;
                    state_next       = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            drop_reg        <= 1'b0;
            found_reg       <= 1'b0;
            best_sq_reg     <= '1;
            best_first_reg  <= '0;
            best_second_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            drop_reg        <= drop_next;
            found_reg       <= found_next;
            best_sq_reg     <= best_sq_next;
            best_first_reg  <= best_first_next;
            best_second_reg <= best_second_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a set without a pair reports zeros
    a_no_pair_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pair_found) |->
            (m_data.min_distance == '0 && m_data.first_index == '0 &&
             m_data.second_index == '0))
        else $error("result without a pair carries nonzero fields");

    // the earlier index always precedes the later one
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.pair_found) |->
            (m_data.first_index < m_data.second_index))
        else $error("closest pair indices out of order");

    // distances reach the comparator only during search or drain
    a_dist_window: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_res.tag.valid |-> (state_reg == ST_SEARCH || state_reg == ST_DRAIN))
        else $error("distance result outside the search window");

    // the point count never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

endmodule

/* hdl/cps_point_store.sv */
module cps_point_store
    import cps_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  point_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr_a,
    input  logic [IDX_W-1:0] rd_addr_b,
    output point_t           rd_data_a,
    output point_t           rd_data_b
);

    point_t point_mem [MAX_POINTS];
    point_t rd_a_reg;
    point_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            point_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= point_mem[rd_addr_a];
        rd_b_reg <= point_mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* hdl/cps_dist_unit.sv */
module cps_dist_unit
    import cps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pair_tag_t in_tag,
    input  point_t    pt_a,
    input  point_t    pt_b,
    output dist_res_t res,
    output logic      busy
);

    // stage 1: differences, stage 2: squares, stage 3: sum
    pair_tag_t                 tag1_reg, tag2_reg, tag3_reg;
    logic signed [COORD_W:0]   dx_reg, dy_reg, dz_reg;
    logic [PART_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic [COORD_W:0]          mag_x, mag_y, mag_z;

    always_comb begin
        mag_x = dx_reg[COORD_W] ? (~dx_reg + 1'b1) : dx_reg;
        mag_y = dy_reg[COORD_W] ? (~dy_reg + 1'b1) : dy_reg;
        mag_z = dz_reg[COORD_W] ? (~dz_reg + 1'b1) : dz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
            tag3_reg.valid <= 1'b0;
        end else begin
            tag1_reg.valid <= in_tag.valid;
            tag2_reg.valid <= tag1_reg.valid;
            tag3_reg.valid <= tag2_reg.valid;
        end
        tag1_reg.first  <= in_tag.first;
        tag1_reg.second <= in_tag.second;
        tag2_reg.first  <= tag1_reg.first;
        tag2_reg.second <= tag1_reg.second;
        tag3_reg.first  <= tag2_reg.first;
        tag3_reg.second <= tag2_reg.second;
        dx_reg  <= (COORD_W+1)'(pt_b.x) - (COORD_W+1)'(pt_a.x);
        dy_reg  <= (COORD_W+1)'(pt_b.y) - (COORD_W+1)'(pt_a.y);
        dz_reg  <= (COORD_W+1)'(pt_b.z) - (COORD_W+1)'(pt_a.z);
        sqx_reg <= PART_W'(mag_x[COORD_W-1:0]) * PART_W'(mag_x[COORD_W-1:0]);
        sqy_reg <= PART_W'(mag_y[COORD_W-1:0]) * PART_W'(mag_y[COORD_W-1:0]);
        sqz_reg <= PART_W'(mag_z[COORD_W-1:0]) * PART_W'(mag_z[COORD_W-1:0]);
        sum_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg) + SQ_W'(sqz_reg);
    end

    assign res.tag    = tag3_reg;
    assign res.square = sum_reg;
    assign busy       = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule

/* hdl/cps_isqrt.sv */
module cps_isqrt
    import cps_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [SQ_W-1:0] radicand,
    output sqrt_res_t       res
);

    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SQ_W-1:0]   val_reg, val_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], val_reg[SQ_W-1:SQ_W-2]};
        trial     = REM_W'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = STEP_W'(ROOT_W - 1);
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            // one root bit per step
            val_next = {val_reg[SQ_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.busy = busy_reg;
    assign res.root = root_reg;

endmodule

/* tb/cps_pair_checker.sv */
module cps_pair_checker
    import cps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  cps_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  cps_out_t m_data,
    output int       mismatch_count,
    output int       results_waiting
);

    localparam int MAX_PRINTED = 100;

    point_t   loaded_points [MAX_POINTS];
    int       loaded_count;
    logic     points_dropped;
    int       results_seen;
    cps_out_t closest_pair_q [$];

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Build the root one bit at a time, most significant first.
    function automatic logic [ROOT_W-1:0] floor_root(input longint sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        return ROOT_W'(root);
    endfunction

    // Scan every pair of the held set; strict compare keeps the first of a tie.
    function automatic cps_out_t closest_pair_of_set();
        cps_out_t res;
        longint   best_sq;
        longint   sq;
        longint   dx;
        longint   dy;
        longint   dz;
        int       best_i;
        int       best_j;
        best_sq = (longint'(1) << SQ_W) - 1;
        best_i  = 0;
        best_j  = 0;
        for (int i = 0; i + 1 < loaded_count; i++) begin
            for (int j = i + 1; j < loaded_count; j++) begin
                dx = longint'(loaded_points[j].x) - longint'(loaded_points[i].x);
                dy = longint'(loaded_points[j].y) - longint'(loaded_points[i].y);
                dz = longint'(loaded_points[j].z) - longint'(loaded_points[i].z);
                sq = dx * dx + dy * dy + dz * dz;
                if (sq < best_sq) begin
                    best_sq = sq;
                    best_i  = i;
                    best_j  = j;
                end
            end
        end
        res = '0;
        if (loaded_count >= 2) begin
            res.min_distance = floor_root(best_sq);
            res.first_index  = OUT_IDX_W'(best_i);
            res.second_index = OUT_IDX_W'(best_j);
            res.pair_found   = 1'b1;
        end
        res.overflowed = points_dropped;
        return res;
    endfunction

    task automatic compare_result(input cps_out_t got, input cps_out_t want);
        if (got.min_distance !== want.min_distance)
            report_mismatch($sformatf("result %0d min_distance got %0d want %0d",
                results_seen, got.min_distance, want.min_distance));
        if (got.first_index !== want.first_index)
            report_mismatch($sformatf("result %0d first_index got %0d want %0d",
                results_seen, got.first_index, want.first_index));
        if (got.second_index !== want.second_index)
            report_mismatch($sformatf("result %0d second_index got %0d want %0d",
                results_seen, got.second_index, want.second_index));
        if (got.pair_found !== want.pair_found)
            report_mismatch($sformatf("result %0d pair_found got %0b want %0b",
                results_seen, got.pair_found, want.pair_found));
        if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("result %0d overflowed got %0b want %0b",
                results_seen, got.overflowed, want.overflowed));
    endtask

    always @(posedge aclk) begin
        cps_out_t want;
        if (!aresetn) begin
            loaded_count    = 0;
            points_dropped  = 1'b0;
            results_seen    = 0;
            mismatch_count  = 0;
            results_waiting = 0;
            closest_pair_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (closest_pair_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no set closed",
                        results_seen));
                end else begin
                    want = closest_pair_q.pop_front();
                    compare_result(m_data, want);
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                if (loaded_count < MAX_POINTS) begin
                    loaded_points[loaded_count] = '{x: s_data.x_coord, y: s_data.y_coord,
                                                    z: s_data.z_coord};
                    loaded_count++;
                end else begin
                    points_dropped = 1'b1;
                end
                if (s_data.last_point) begin
                    closest_pair_q = {closest_pair_q, closest_pair_of_set()};
                    loaded_count   = 0;
                    points_dropped = 1'b0;
                end
            end
            results_waiting = closest_pair_q.size();
        end
    end

endmodule

/* tb/closest_pair_search_unit_tb.sv */
module closest_pair_search_unit_tb;
    import cps_pkg::*;

    // The longest quiet stretch in a correct run is the search of a full store;
    // allow roughly three times that.
    localparam int IDLE_LIMIT      = 1_600_000;
    localparam int TAIL_CYCLES     = 64;
    localparam int TARGET_POINTS   = 1170;
    localparam int MIN_RANDOM_SETS = 16;
    localparam int COORD_LO        = -(2 ** (COORD_W - 1));
    localparam int COORD_HI        = 2 ** (COORD_W - 1) - 1;
    localparam int CLOUD_SIZE      = MAX_POINTS + 2;

    typedef enum int {
        STYLE_SPREAD,
        STYLE_CLUSTER,
        STYLE_EDGE,
        STYLE_MIXED
    } coord_style_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cps_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cps_out_t m_data;

    int mismatch_count;
    int results_waiting;
    int idle_cycles = 0;
    int points_sent = 0;
    bit no_gaps     = 1'b0;

    always #5 aclk = ~aclk;

    closest_pair_search_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cps_pair_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting)
    );

    // Idle gap before each transfer; zero throughout a burst with no gaps.
    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic cps_in_t make_point(input int x, input int y, input int z,
                                           input bit last);
        cps_in_t item;
        item.x_coord    = COORD_W'(x);
        item.y_coord    = COORD_W'(y);
        item.z_coord    = COORD_W'(z);
        item.last_point = last;
        return item;
    endfunction

    // Spread covers every coordinate bit; cluster forces ties and duplicates;
    // edge sits on and next to the range limits and zero.
    function automatic int pick_coord(input coord_style_t style);
        case (style)
            STYLE_SPREAD:  return int'($urandom_range(0, 2 ** COORD_W - 1)) + COORD_LO;
            STYLE_CLUSTER: return int'($urandom_range(0, 16)) - 8;
            STYLE_EDGE: begin
                case ($urandom_range(0, 6))
                    0:       return COORD_LO;
                    1:       return COORD_LO + 1;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    5:       return COORD_HI - 1;
                    default: return COORD_HI;
                endcase
            end
            default:       return pick_coord(coord_style_t'($urandom_range(0, 2)));
        endcase
    endfunction

    // Call at a falling edge; return at the falling edge after the transfer.
    // Valid drops only during a gap, so it is never lowered and raised in one step.
    task automatic send_point(input cps_in_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        points_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_set(input int size, input coord_style_t style);
        for (int k = 0; k < size; k++) begin
            send_point(make_point(pick_coord(style), pick_coord(style), pick_coord(style),
                                  k == size - 1));
        end
    endtask

    // Result side: stall a random number of cycles, then hold ready until a transfer.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("closest_pair_search_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int           cloud_x [CLOUD_SIZE];
        int           cloud_y [CLOUD_SIZE];
        int           cloud_z [CLOUD_SIZE];
        int           near_a;
        int           near_b;
        int           set_size;
        int           random_sets;
        coord_style_t style;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-point sets: no pair to report.
        send_point(make_point(0, 0, 0, 1'b1));
        send_point(make_point(COORD_LO, COORD_LO, COORD_LO, 1'b1));
        // Opposite corners give the largest possible distance.
        send_point(make_point(COORD_LO, COORD_LO, COORD_LO, 1'b0));
        send_point(make_point(COORD_HI, COORD_HI, COORD_HI, 1'b1));
        // Equal distances: the first pair scanned must win.
        send_point(make_point(0, 0, 0, 1'b0));
        send_point(make_point(1, 0, 0, 1'b0));
        send_point(make_point(2, 0, 0, 1'b1));
        // Duplicate points at the ends of the set: zero distance.
        send_point(make_point(5, -7, 9, 1'b0));
        send_point(make_point(100, 200, 300, 1'b0));
        send_point(make_point(5, -7, 9, 1'b1));
        // Mixed signs near the limits.
        send_point(make_point(COORD_HI, 0, COORD_LO, 1'b0));
        send_point(make_point(-1, -1, -1, 1'b0));
        send_point(make_point(0, 1, 0, 1'b0));
        send_point(make_point(COORD_HI - 1, 1, COORD_LO + 1, 1'b1));
        // Squared distance 48: root must round down to 6.
        send_point(make_point(0, 0, 0, 1'b0));
        send_point(make_point(4, 4, 4, 1'b1));
        send_point(make_point(COORD_LO, COORD_HI, 0, 1'b0));
        send_point(make_point(COORD_HI, COORD_LO, -1, 1'b1));

        // Overfill the store: two points beyond capacity, the dropped last one
        // still closes the set. Plant a duplicate so the winning pair lands at
        // random indices across the whole index range.
        for (int i = 0; i < CLOUD_SIZE; i++) begin
            cloud_x[i] = pick_coord(STYLE_SPREAD);
            cloud_y[i] = pick_coord(STYLE_SPREAD);
            cloud_z[i] = pick_coord(STYLE_SPREAD);
        end
        near_a = $urandom_range(0, MAX_POINTS - 2);
        near_b = $urandom_range(near_a + 1, MAX_POINTS - 1);
        cloud_x[near_b] = cloud_x[near_a];
        cloud_y[near_b] = cloud_y[near_a];
        cloud_z[near_b] = cloud_z[near_a];
        for (int i = 0; i < CLOUD_SIZE; i++) begin
            send_point(make_point(cloud_x[i], cloud_y[i], cloud_z[i], i == CLOUD_SIZE - 1));
        end

        // Random sets: mostly small, a few larger; some bursts run without gaps.
        random_sets = 0;
        while (points_sent < TARGET_POINTS || random_sets < MIN_RANDOM_SETS) begin
            no_gaps  = ($urandom_range(0, 3) == 0);
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48)
                                                   : $urandom_range(1, 8);
            style    = coord_style_t'($urandom_range(0, 3));
            send_random_set(set_size, style);
            random_sets++;
        end
        no_gaps = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait for every closed set to report, then let the pipe settle.
        while (results_waiting != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && results_waiting == 0) begin
            $display("closest_pair_search_unit test passed");
        end else begin
            $display("closest_pair_search_unit test failed");
        end
        $finish;
    end

endmodule
